// File: rtl/nmt_pkg.sv
// Shared types, constants and helpers for the normal-matrix transform.
`timescale 1ns / 1ps

package nmt_pkg;

  // Packed width of one matrix entry inside a row register
  localparam int CompW = 16;
  localparam int RowW  = 48;

  // Determinant threshold in Q.36 and unit length in Q1.14
  localparam int DetEps = 687;
  localparam int Unit   = 16384;

  // Reset rows give the identity matrix in Q4.12
  localparam logic [RowW-1:0] Row0Rst = 48'd4096;
  localparam logic [RowW-1:0] Row1Rst = 48'd268435456;
  localparam logic [RowW-1:0] Row2Rst = 48'd17592186044416;

  // Depth of the item queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  typedef enum logic [1:0] {
    CFG_ROW0 = 2'd0,
    CFG_ROW1 = 2'd1,
    CFG_ROW2 = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               last_in;
  } item_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic               last_out;
  } result_t;

  typedef struct packed {
    logic [RowW-1:0] row0;
    logic [RowW-1:0] row1;
    logic [RowW-1:0] row2;
  } matrix_t;

  // Head of the item queue as seen by the back part
  typedef struct packed {
    logic  valid;
    item_t item;
  } fb_t;

  // Extract one entry of a row and bring it to Q4.12
  function automatic logic signed [15:0] entry_q12(logic [RowW-1:0] row, int col);
    int          pos;
    logic [47:0] raw;
    pos = col * CompW;
    raw = '0;
    if (pos < RowW) begin
      raw = (row >> pos) & ((48'(1) << CompW) - 48'(1));
      if (CompW >= 16) raw = raw >> (CompW - 16);
      else raw = raw << (16 - CompW);
    end
    return raw[15:0];
  endfunction

endpackage

// File: rtl/nmt_front.sv
// Front part: accept items into a short queue that feeds the back part.
`timescale 1ns / 1ps

module nmt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  nmt_pkg::item_t item_i,
  output nmt_pkg::fb_t  head_o,
  input  logic          back_rdy_i
);
  import nmt_pkg::*;

  item_t             mem_q [QDepth];
  logic [QPtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [QPtrW:0]    cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full    = (cnt_q == (QPtrW+1)'(QDepth));
  assign do_push = push && !full;
  assign do_pop  = back_rdy_i && (cnt_q != '0);

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_q];

  // Advance pointers and fill count
  always_comb begin
    wr_d  = do_push ? wr_q + QPtrW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + QPtrW'(1) : rd_q;
    cnt_d = cnt_q + (QPtrW+1)'(do_push) - (QPtrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store accepted item
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end

endmodule

// File: rtl/nmt_back.sv
// Back part: cofactor transform, length, normalization and result queue.
`timescale 1ns / 1ps

module nmt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  nmt_pkg::matrix_t mat_i,
  input  nmt_pkg::fb_t     head_i,
  output logic             rdy_o,
  output logic             empty,
  input  logic             pop,
  output nmt_pkg::result_t result_o
);
  import nmt_pkg::*;

  localparam int SqBase  = 9;
  localparam int NumStg  = SqBase + 32;
  localparam int DivBase = NumStg + 1;
  localparam int NStg    = DivBase + 15;
  localparam int MagStg  = 6;
  localparam int MW      = 50;

  typedef struct packed {
    logic [2:0] sgn;
    logic       last;
  } tag_t;

  logic               en;
  logic [NStg-1:0]    vld_q;
  tag_t               tg_q [NStg];

  logic signed [15:0] ent [9];
  logic signed [31:0] pp_q [9][2];
  logic signed [32:0] cof_q [9];
  logic signed [15:0] n1_q [3], n2_q [3];
  logic signed [48:0] dp_q [3];
  logic signed [48:0] vp_q [3][3];
  logic signed [50:0] det_q;
  logic signed [50:0] v_q [3];
  logic [MW-1:0]      mag_q [3];
  logic [MW-1:0]      mag6_q [3];
  logic [4:0]         sh_q;
  logic [30:0]        mg_q [MagStg:NStg-1][3];
  logic [61:0]        sq_q [3];
  logic [63:0]        sum_q;
  logic [63:0]        sx_q [32], sr_q [32];
  logic [63:0]        sx_d [32], sr_d [32];
  logic [31:0]        len_q [NumStg:NStg-1];
  logic [46:0]        rem_q [NumStg:NStg-1][3];
  logic [14:0]        qt_q [DivBase:NStg-1][3];
  logic [46:0]        rem_d [DivBase:NStg-1][3];
  logic [14:0]        qt_d [DivBase:NStg-1][3];

  // Output queue
  result_t            oq_q [2];
  logic               owr_q, ord_q;
  logic [1:0]         ocnt_q;
  result_t            res;
  logic               owr, ord;

  // Pipeline moves while the output queue has room
  assign en    = (ocnt_q != 2'd2);
  assign rdy_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[NStg-2:0], head_i.valid};
  end

  // Matrix entries, row-major a..i
  always_comb begin
    ent[0] = entry_q12(mat_i.row0, 0);
    ent[1] = entry_q12(mat_i.row0, 1);
    ent[2] = entry_q12(mat_i.row0, 2);
    ent[3] = entry_q12(mat_i.row1, 0);
    ent[4] = entry_q12(mat_i.row1, 1);
    ent[5] = entry_q12(mat_i.row1, 2);
    ent[6] = entry_q12(mat_i.row2, 0);
    ent[7] = entry_q12(mat_i.row2, 1);
    ent[8] = entry_q12(mat_i.row2, 2);
  end

  function automatic logic neg_flag();
    return (det_q < 0) && (det_q >= -51'sd687);
  endfunction

  function automatic logic signed [50:0] v_fix(int i);
    return neg_flag() ? -v_q[i] : v_q[i];
  endfunction

  function automatic logic v_sign(int i);
    logic signed [50:0] t;
    t = v_fix(i);
    return t[50];
  endfunction

  // Carry tags down the pipeline; signs are set once the vector is known
  always_ff @(posedge clk_i) begin
    if (en) begin
      tg_q[0] <= '{sgn: 3'b000, last: head_i.item.last_in};
      for (int t = 1; t < NStg; t++) begin
        if (t != 4) tg_q[t] <= tg_q[t-1];
      end
      tg_q[4] <= '{sgn: {v_sign(2), v_sign(1), v_sign(0)}, last: tg_q[3].last};
    end
  end

  // Cofactor products, then cofactors, then transform and determinant
  always_ff @(posedge clk_i) begin
    if (en) begin
      pp_q[0][0] <= ent[4] * ent[8]; pp_q[0][1] <= ent[5] * ent[7];
      pp_q[1][0] <= ent[5] * ent[6]; pp_q[1][1] <= ent[3] * ent[8];
      pp_q[2][0] <= ent[3] * ent[7]; pp_q[2][1] <= ent[4] * ent[6];
      pp_q[3][0] <= ent[2] * ent[7]; pp_q[3][1] <= ent[1] * ent[8];
      pp_q[4][0] <= ent[0] * ent[8]; pp_q[4][1] <= ent[2] * ent[6];
      pp_q[5][0] <= ent[1] * ent[6]; pp_q[5][1] <= ent[0] * ent[7];
      pp_q[6][0] <= ent[1] * ent[5]; pp_q[6][1] <= ent[2] * ent[4];
      pp_q[7][0] <= ent[2] * ent[3]; pp_q[7][1] <= ent[0] * ent[5];
      pp_q[8][0] <= ent[0] * ent[4]; pp_q[8][1] <= ent[1] * ent[3];
      n1_q[0] <= head_i.item.normal_x;
      n1_q[1] <= head_i.item.normal_y;
      n1_q[2] <= head_i.item.normal_z;
      for (int i = 0; i < 9; i++) cof_q[i] <= 33'(pp_q[i][0]) - 33'(pp_q[i][1]);
      n2_q <= n1_q;
      for (int j = 0; j < 3; j++) dp_q[j] <= 49'(ent[j]) * 49'(cof_q[j]);
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) vp_q[i][j] <= 49'(cof_q[3*i+j]) * 49'(n2_q[j]);
      end
      det_q <= 51'(dp_q[0]) + 51'(dp_q[1]) + 51'(dp_q[2]);
      for (int i = 0; i < 3; i++) v_q[i] <= 51'(vp_q[i][0]) + 51'(vp_q[i][1]) + 51'(vp_q[i][2]);
    end
  end

  // Magnitudes, scale shift, squares and their sum
  always_ff @(posedge clk_i) begin
    logic signed [50:0] t;
    logic [MW-1:0]      orv;
    logic [4:0]         s;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t = v_fix(i);
        mag_q[i] <= t[50] ? MW'(-t) : MW'(t);
      end
      orv = mag_q[0] | mag_q[1] | mag_q[2];
      s = '0;
      for (int b = 31; b < MW; b++) if (orv[b]) s = 5'(b - 30);
      sh_q   <= s;
      mag6_q <= mag_q;
      for (int i = 0; i < 3; i++) mg_q[MagStg][i] <= 31'(mag6_q[i] >> sh_q);
      for (int t2 = MagStg + 1; t2 < NStg; t2++) mg_q[t2] <= mg_q[t2-1];
      for (int i = 0; i < 3; i++) sq_q[i] <= 62'(mg_q[MagStg][i]) * 62'(mg_q[MagStg][i]);
      sum_q <= 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]);
    end
  end

  // Square root, one result bit per stage
  always_comb begin
    logic [63:0] xin, rin, bitv;
    logic [64:0] tr;
    for (int j = 0; j < 32; j++) begin
      xin  = (j == 0) ? sum_q : sx_q[(j == 0) ? 0 : j-1];
      rin  = (j == 0) ? 64'd0 : sr_q[(j == 0) ? 0 : j-1];
      bitv = 64'(1) << (62 - 2*j);
      tr   = {1'b0, rin} + {1'b0, bitv};
      if ({1'b0, xin} >= tr) begin
        sx_d[j] = xin - tr[63:0];
        sr_d[j] = (rin >> 1) + bitv;
      end else begin
        sx_d[j] = xin;
        sr_d[j] = rin >> 1;
      end
    end
  end

  // Restoring divide, one quotient bit per stage
  always_comb begin
    logic [46:0] rin, dv;
    logic [14:0] qin;
    for (int k = DivBase; k < NStg; k++) begin
      rin = 47'(0);
      qin = '0;
      for (int i = 0; i < 3; i++) begin
        rin = rem_q[k-1][i];
        qin = (k == DivBase) ? 15'd0 : qt_q[(k == DivBase) ? DivBase : k-1][i];
        dv  = 47'(len_q[k-1]) << (14 - (k - DivBase));
        if (rin >= dv) begin
          rem_d[k][i] = rin - dv;
          qt_d[k][i]  = qin | (15'(1) << (14 - (k - DivBase)));
        end else begin
          rem_d[k][i] = rin;
          qt_d[k][i]  = qin;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 32; j++) begin
        sx_q[j] <= sx_d[j];
        sr_q[j] <= sr_d[j];
      end
      len_q[NumStg] <= sr_q[31][31:0];
      for (int i = 0; i < 3; i++) begin
        rem_q[NumStg][i] <= 47'({mg_q[NumStg-1][i], 14'd0}) + 47'(sr_q[31][31:1]);
      end
      for (int k = DivBase; k < NStg; k++) begin
        len_q[k] <= len_q[k-1];
        rem_q[k] <= rem_d[k];
        qt_q[k]  <= qt_d[k];
      end
    end
  end

  // Clamp, apply sign and form the result
  function automatic logic signed [15:0] comp(int i);
    logic [14:0] q;
    q = qt_q[NStg-1][i];
    if (len_q[NStg-1] == '0) q = '0;
    else if (q > 15'(Unit)) q = 15'(Unit);
    return tg_q[NStg-1].sgn[i] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  always_comb begin
    res.out_x    = comp(0);
    res.out_y    = comp(1);
    res.out_z    = comp(2);
    res.last_out = tg_q[NStg-1].last;
  end

  // Output queue
  assign owr      = en && vld_q[NStg-1];
  assign ord      = pop && !empty;
  assign empty    = (ocnt_q == 2'd0);
  assign result_o = oq_q[ord_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
      ocnt_q <= '0;
    end else begin
      if (owr) owr_q <= ~owr_q;
      if (ord) ord_q <= ~ord_q;
      ocnt_q <= ocnt_q + 2'(owr) - 2'(ord);
    end
  end

  always_ff @(posedge clk_i) begin
    if (owr) oq_q[owr_q] <= res;
  end

endmodule

// File: rtl/normal_matrix_transform.sv
// Top level: configuration rows, front queue and back pipeline.
`timescale 1ns / 1ps

// Transforms a stream of Q1.14 normals by the cofactor matrix of the 3x3
// model matrix held in three row registers and returns unit-length Q1.14
// normals, negated when the determinant is slightly negative (|det| at or
// below epsilon). While the output queue has room, one item is taken per
// cycle and one result delivered per cycle. The back part is fully
// pipelined (cofactor and transform multiplies, a 32-stage square root
// and a 15-stage divide). Items wait in a four-entry queue at the input
// and a two-entry queue at the output; the back pipeline holds while the
// output queue is full. Write the matrix rows only while no item is in
// flight; the configuration port is always ready.
module normal_matrix_transform (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  nmt_pkg::item_t   item_i,
  output logic             empty,
  input  logic             pop,
  output nmt_pkg::result_t result_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [47:0]      cfg_data_i
);
  import nmt_pkg::*;

  matrix_t mat_q;
  fb_t     head;
  logic    back_rdy;

  assign cfg_ready_o = 1'b1;

  // Hold the matrix rows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q.row0 <= Row0Rst;
      mat_q.row1 <= Row1Rst;
      mat_q.row2 <= Row2Rst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ROW0: mat_q.row0 <= cfg_data_i;
        CFG_ROW1: mat_q.row1 <= cfg_data_i;
        CFG_ROW2: mat_q.row2 <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  nmt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .item_i     (item_i),
    .head_o     (head),
    .back_rdy_i (back_rdy)
  );

  nmt_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .mat_i    (mat_q),
    .head_i   (head),
    .rdy_o    (back_rdy),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

endmodule

// File: sim/tb_normal_matrix_transform.sv
// Testbench for the normal-matrix transform: directed and random normals checked against a predictor.
`timescale 1ns / 1ps

module tb_normal_matrix_transform;
  import nmt_pkg::*;

  // Index outside the three rows; a write to it must change nothing
  localparam logic [1:0] CfgUnused = 2'd3;

  logic             clk_i;
  logic             rst_ni;
  logic             push;
  logic             full;
  item_t            item_i;
  logic             empty;
  logic             pop;
  result_t          result_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [1:0]       cfg_index_i;
  logic [47:0]      cfg_data_i;

  // Predictor copy of the matrix rows
  logic [47:0]      model_rows [3];
  result_t          pending_normals [$];
  int               errors;
  int               send_idle_pct;
  int               pop_stall_pct;
  int               holdoff_cycles;

  normal_matrix_transform dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Signed Q4.12 entry of a row
  function automatic longint row_entry(logic [47:0] row, int col);
    logic signed [15:0] raw;
    raw = row[col*16 +: 16];
    return longint'(raw);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x    = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Unit normal of cofactor matrix times n, flipped on a small negative determinant
  function automatic result_t transform_normal(item_t it);
    longint          m [9];
    longint          cof [9];
    longint          n [3];
    longint          v [3];
    longint          det;
    longint unsigned mag [3];
    longint unsigned peak, sum, len, q;
    logic [15:0]     comp [3];
    int              s;
    result_t         res;
    for (int i = 0; i < 9; i++) m[i] = row_entry(model_rows[i/3], i%3);
    cof[0] = m[4]*m[8] - m[5]*m[7];
    cof[1] = -(m[3]*m[8] - m[5]*m[6]);
    cof[2] = m[3]*m[7] - m[4]*m[6];
    cof[3] = -(m[1]*m[8] - m[2]*m[7]);
    cof[4] = m[0]*m[8] - m[2]*m[6];
    cof[5] = -(m[0]*m[7] - m[1]*m[6]);
    cof[6] = m[1]*m[5] - m[2]*m[4];
    cof[7] = -(m[0]*m[5] - m[2]*m[3]);
    cof[8] = m[0]*m[4] - m[1]*m[3];
    det = m[0]*cof[0] + m[1]*cof[1] + m[2]*cof[2];
    n[0] = longint'(it.normal_x);
    n[1] = longint'(it.normal_y);
    n[2] = longint'(it.normal_z);
    for (int i = 0; i < 3; i++) begin
      v[i] = cof[3*i]*n[0] + cof[3*i+1]*n[1] + cof[3*i+2]*n[2];
      if (det < 0 && det >= -longint'(DetEps)) v[i] = -v[i];
      mag[i] = (v[i] < 0) ? longint'(-v[i]) : v[i];
    end
    peak = mag[0];
    if (mag[1] > peak) peak = mag[1];
    if (mag[2] > peak) peak = mag[2];
    s = 0;
    while ((peak >> s) >= 64'h8000_0000) s++;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = mag[i] >> s;
      sum    = sum + mag[i]*mag[i];
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = 0;
      if (len != 0) begin
        q = (mag[i]*Unit + len/2) / len;
        if (q > Unit) q = Unit;
      end
      comp[i] = (v[i] < 0) ? 16'(-q) : 16'(q);
    end
    res.out_x    = comp[0];
    res.out_y    = comp[1];
    res.out_z    = comp[2];
    res.last_out = it.last_in;
    return res;
  endfunction

  // Offer one item after a random idle gap; record its expected normal on acceptance
  task automatic send_normal(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
    @(negedge clk_i);
    push   <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full);
    pending_normals = {pending_normals, transform_normal(it)};
  endtask

  task automatic send_vec(int x, int y, int z, bit last);
    item_t it;
    it.normal_x = 16'(x);
    it.normal_y = 16'(y);
    it.normal_z = 16'(z);
    it.last_in  = last;
    send_normal(it);
  endtask

  function automatic item_t random_normal();
    item_t it;
    it = item_t'(49'({$urandom, $urandom}));
    // Mostly unit-scale normals, with full-range noise mixed in
    if ($urandom_range(3) != 0) begin
      it.normal_x = 16'($urandom_range(32768) - 16384);
      it.normal_y = 16'($urandom_range(32768) - 16384);
      it.normal_z = 16'($urandom_range(32768) - 16384);
    end
    return it;
  endfunction

  // Drop push, wait until every expected item has come out, then let the pipe settle
  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_normals.size() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic write_row(logic [1:0] idx, logic [47:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx != CfgUnused) model_rows[idx] = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_matrix(logic [47:0] r0, logic [47:0] r1, logic [47:0] r2);
    write_row(CFG_ROW0, r0);
    write_row(CFG_ROW1, r1);
    write_row(CFG_ROW2, r2);
  endtask

  function automatic logic [47:0] random_row();
    logic [47:0] row;
    for (int c = 0; c < 3; c++) begin
      if ($urandom_range(2) == 0) row[c*16 +: 16] = 16'($urandom);
      else row[c*16 +: 16] = 16'($urandom_range(16384) - 8192);
    end
    return row;
  endfunction

  task automatic test_identity_extremes();
    send_vec(0, 0, 0, 1'b0);
    send_vec(16384, 0, 0, 1'b0);
    send_vec(0, -16384, 0, 1'b0);
    send_vec(0, 0, 16384, 1'b1);
    send_vec(-32768, -32768, -32768, 1'b0);
    send_vec(32767, 32767, 32767, 1'b1);
    send_vec(32767, -32768, 1, 1'b0);
    send_vec(-1, 1, -1, 1'b1);
    send_vec(9459, 9459, -9459, 1'b0);
    drain();
  endtask

  task automatic test_matrix_extremes();
    load_matrix(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000);
    send_vec(16384, 16384, 16384, 1'b0);
    drain();
    load_matrix(48'h7FFF_0000_7FFF, 48'h0000_7FFF_8000, 48'h8000_7FFF_7FFF);
    send_vec(32767, -32768, 12345, 1'b1);
    send_vec(-32768, 32767, -1, 1'b0);
    drain();
    // Ignored index leaves row 0 alone
    write_row(CfgUnused, 48'hFFFF_FFFF_FFFF);
    send_vec(1000, -2000, 3000, 1'b0);
    drain();
  endtask

  task automatic test_small_determinant();
    // Negative determinant inside epsilon: result flips
    load_matrix(48'h0000_0000_0001, 48'h0000_0001_0000, 48'hFFFF_0000_0000);
    send_vec(16384, 8192, -4096, 1'b0);
    send_vec(-300, 7, 16000, 1'b1);
    drain();
    // Exactly minus epsilon stays flipped
    load_matrix(48'h0000_0000_0001, 48'h0000_0001_0000, 48'hFD51_0000_0000);
    send_vec(5000, -6000, 7000, 1'b0);
    drain();
    // Zero determinant with nonzero cofactors: no flip
    load_matrix(48'h0000_1000_1000, 48'h0000_1000_1000, 48'h1000_0000_0000);
    send_vec(16384, 0, 0, 1'b0);
    send_vec(0, 16384, -16384, 1'b1);
    drain();
    // Zero matrix gives a zero-length vector
    load_matrix(48'h0, 48'h0, 48'h0);
    send_vec(16384, -16384, 100, 1'b1);
    drain();
  endtask

  task automatic test_random_phase(int count, int send_pct, int stall_pct);
    load_matrix(random_row(), random_row(), random_row());
    send_idle_pct = send_pct;
    pop_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      // Swap in a fresh matrix every so often between drained batches
      if (i % 45 == 44) begin
        drain();
        load_matrix(random_row(), random_row(), random_row());
      end
      send_normal(random_normal());
    end
    drain();
    send_idle_pct = 0;
    pop_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    load_matrix(random_row(), random_row(), random_row());
    holdoff_cycles = 300;
    for (int i = 0; i < 100; i++) send_normal(random_normal());
    drain();
  endtask

  // Hold pop low during a hold-off, otherwise stall at random
  always @(negedge clk_i) begin
    if (holdoff_cycles > 0) begin
      holdoff_cycles <= holdoff_cycles - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // Compare each popped item with the oldest expected normal
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && pop && !empty) begin
      if (pending_normals.size() == 0) begin
        $display("%0t: unexpected item %h", $time, result_o);
        errors++;
      end else begin
        exp_r = pending_normals.pop_front();
        if (result_o.out_x !== exp_r.out_x) begin
          $display("%0t: out_x exp %0d got %0d", $time, exp_r.out_x, result_o.out_x);
          errors++;
        end
        if (result_o.out_y !== exp_r.out_y) begin
          $display("%0t: out_y exp %0d got %0d", $time, exp_r.out_y, result_o.out_y);
          errors++;
        end
        if (result_o.out_z !== exp_r.out_z) begin
          $display("%0t: out_z exp %0d got %0d", $time, exp_r.out_z, result_o.out_z);
          errors++;
        end
        if (result_o.last_out !== exp_r.last_out) begin
          $display("%0t: last_out exp %0b got %0b", $time, exp_r.last_out, result_o.last_out);
          errors++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    push           = 1'b0;
    item_i         = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_ROW0;
    cfg_data_i     = '0;
    errors         = 0;
    send_idle_pct  = 0;
    pop_stall_pct  = 0;
    holdoff_cycles = 0;
    model_rows[0]  = Row0Rst;
    model_rows[1]  = Row1Rst;
    model_rows[2]  = Row2Rst;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_identity_extremes();
    test_matrix_extremes();
    test_small_determinant();
    test_random_phase(110, 0, 0);
    test_random_phase(110, 83, 0);
    test_random_phase(110, 0, 83);
    test_random_phase(110, 27, 27);
    test_backpressure();

    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
